### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds on an edge, cons must hold on the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold on any edge.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### design/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CP_W  = 21;
   localparam int LEN_W = 3;

   // Byte classification limits
   localparam logic [7:0] ASCII_MAX    = 8'h7F;
   localparam logic [7:0] LEAD2_MIN    = 8'hC2;
   localparam logic [7:0] LEAD3_MIN    = 8'hE0;
   localparam logic [7:0] LEAD4_MIN    = 8'hF0;
   localparam logic [7:0] LEAD_BAD_MIN = 8'hF5;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   // Surrogate range, rejected on completion
   localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

   // Sequence lengths
   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   // Decoder state carried between bytes
   typedef struct packed {
      logic [1:0]       pending;  // continuation bytes still expected, 0 = idle
      logic [CP_W-1:0]  acc;      // payload bits gathered so far
      logic [LEN_W-1:0] total;    // length of the open sequence
   } utf8d_state_type;

   // Result of one decoded byte
   typedef struct packed {
      logic             valid;
      logic [CP_W-1:0]  codepoint;
      logic [LEN_W-1:0] seq_length;
      logic             error;
   } utf8d_result_type;

   localparam utf8d_state_type STATE_IDLE = '{pending: 2'd0, acc: '0, total: '0};

endpackage

### design/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Single-byte decode step: classifies one byte against the open sequence,
// produces the next decoder state and at most one result.
// ----------------------------------------------------------------------------
module utf8d_decode
   import utf8d_pkg::*;
(
   input  logic [7:0]       in_byte,
   input  utf8d_state_type  state_cur,
   output utf8d_state_type  state_nxt,
   output utf8d_result_type result
);

   logic [CP_W-1:0]  acc_shift;
   logic [1:0]       pending_dec;
   logic [LEN_W-1:0] fail_len;
   logic             is_surrogate;

   // Continuation path arithmetic
   assign acc_shift    = {state_cur.acc[CP_W-7:0], in_byte[5:0]};
   assign pending_dec  = state_cur.pending - 2'd1;
   assign fail_len     = state_cur.total - {1'b0, state_cur.pending} + LEN_ONE;
   assign is_surrogate = (acc_shift >= SURR_LO) && (acc_shift <= SURR_HI);

   always_comb begin
      state_nxt = state_cur;
      result    = '{valid: 1'b0, codepoint: '0, seq_length: LEN_ONE, error: 1'b0};

      if (state_cur.pending == 2'd0) begin
         // Idle: expect ASCII or a lead byte
         if (in_byte <= ASCII_MAX) begin
            result.valid     = 1'b1;
            result.codepoint = {{(CP_W-8){1'b0}}, in_byte};
         end else if (in_byte < LEAD2_MIN || in_byte >= LEAD_BAD_MIN) begin
            result.valid = 1'b1;
            result.error = 1'b1;
            state_nxt    = STATE_IDLE;
         end else if (in_byte < LEAD3_MIN) begin
            state_nxt.total   = LEN_TWO;
            state_nxt.pending = 2'd1;
            state_nxt.acc     = {{(CP_W-5){1'b0}}, in_byte[4:0]};
         end else if (in_byte < LEAD4_MIN) begin
            state_nxt.total   = LEN_THREE;
            state_nxt.pending = 2'd2;
            state_nxt.acc     = {{(CP_W-4){1'b0}}, in_byte[3:0]};
         end else begin
            state_nxt.total   = LEN_FOUR;
            state_nxt.pending = 2'd3;
            state_nxt.acc     = {{(CP_W-3){1'b0}}, in_byte[2:0]};
         end
      end else if (in_byte[7:6] != CONT_TAG) begin
         // Broken sequence: drop the byte and go idle
         result.valid      = 1'b1;
         result.error      = 1'b1;
         result.seq_length = fail_len;
         state_nxt         = STATE_IDLE;
      end else if (pending_dec != 2'd0) begin
         // Sequence still open
         state_nxt.acc     = acc_shift;
         state_nxt.pending = pending_dec;
      end else begin
         // Last continuation byte closes the sequence
         result.valid      = 1'b1;
         result.seq_length = state_cur.total;
         result.error      = is_surrogate;
         result.codepoint  = is_surrogate ? '0 : acc_shift;
         state_nxt         = STATE_IDLE;
      end
   end

endmodule

### design/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder. Takes one raw byte per transaction and returns
// one result per finished or failed sequence: the codepoint, the bytes it
// used and an error flag. Bad lead bytes, broken continuations and
// surrogate values are reported with the flag set and codepoint zero; the
// failing byte is dropped and decoding restarts idle. While the output is
// not stalled, bytes are accepted at one per clock without gaps. A result
// is registered: the byte that completes it sits in the input register
// while the decode step runs against the sequence state, and the result
// register loads when the stage advances. The loop through the sequence
// state sets the rate. While a result waits at the output, one more byte
// can enter the input register; after that the input stalls until the
// result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder_unit
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] codepoint, [23:21] seq_length
   output logic        rsp_tuser    // [0] error
);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_byte_ff;
   utf8d_state_type  state_ff;
   utf8d_state_type  state_in;
   utf8d_state_type  state_nxt;
   utf8d_result_type result;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CP_W-1:0]  cp_ff;
   logic [LEN_W-1:0] len_ff;
   logic             err_ff;
   logic             out_free;
   logic             stage_fire;
   logic             req_take;
   logic             chk_cp_surr;
   logic             chk_len_ok;
   logic             chk_state_ok;

   // Handshake and stage advance
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_fire = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || stage_fire;
   assign req_take   = req_tvalid && req_tready;

   // Decode step
   utf8d_decode u_decode (
      .in_byte   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result)
   );

   // Next values for the control registers
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !stage_fire);
      state_in     = stage_fire ? state_nxt : state_ff;
      rsp_valid_in = stage_fire ? result.valid : (rsp_valid_ff && !rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      if (stage_fire && result.valid) begin
         cp_ff  <= result.codepoint;
         len_ff <= result.seq_length;
         err_ff <= result.error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {len_ff, cp_ff};
   assign rsp_tuser  = err_ff;

   // Check terms
   assign chk_cp_surr  = (cp_ff >= SURR_LO) && (cp_ff <= SURR_HI);
   assign chk_len_ok   = (len_ff >= LEN_ONE) && (len_ff <= LEN_FOUR);
   assign chk_state_ok = (state_ff.total >= LEN_TWO)
                         && ({1'b0, state_ff.pending} < state_ff.total);

   // Checks
   `ASSERT_IMPLIES(a_err_cp_zero, rsp_tvalid && rsp_tuser, cp_ff == '0, "error with codepoint")
   `ASSERT_IMPLIES(a_len_range, rsp_tvalid, chk_len_ok, "sequence length out of range")
   `ASSERT_IMPLIES(a_no_surrogate, rsp_tvalid && !rsp_tuser, !chk_cp_surr, "surrogate passed")
   `ASSERT_IMPLIES(a_state_sane, state_ff.pending != 2'd0, chk_state_ok, "bad pending count")

endmodule
